// File: hw/rtl/assert_macros.svh
// Assertion macros shared by the clipper RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define CSER_ASSERT_IMP(name, clk, rstn, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("clipper assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define CSER_ASSERT_NXT(name, clk, rstn, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("clipper assertion failed");

`endif

// File: hw/rtl/cser_pkg.sv
// Shared constants and types for the segment end clipper.
package cser_pkg;

    // Width of the configuration register index.
    localparam int CFG_IDX_W = 3;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_LEFT   = 3'd0,
        CFG_TOP    = 3'd1,
        CFG_RIGHT  = 3'd2,
        CFG_BOTTOM = 3'd3,
        CFG_MARGIN = 3'd4
    } cser_cfg_idx_t;

    // Width of the edge margin register.
    localparam int MARGIN_W = 16;

endpackage

// File: hw/rtl/cser_if.sv
// Stream interfaces for segment words and clipped point words.
interface cser_in_if #(parameter int W = 24);
    logic                valid;
    logic                ready;
    logic signed [W-1:0] inside_x;
    logic signed [W-1:0] inside_y;
    logic signed [W-1:0] outside_x;
    logic signed [W-1:0] outside_y;

    modport source (output valid, inside_x, inside_y, outside_x, outside_y, input ready);
    modport sink   (input valid, inside_x, inside_y, outside_x, outside_y, output ready);
endinterface

interface cser_out_if #(parameter int W = 24);
    logic                valid;
    logic                ready;
    logic signed [W-1:0] clipped_x;
    logic signed [W-1:0] clipped_y;
    logic                x_was_clamped;
    logic                y_was_clamped;

    modport source (output valid, clipped_x, clipped_y, x_was_clamped, y_was_clamped,
                    input ready);
    modport sink   (input valid, clipped_x, clipped_y, x_was_clamped, y_was_clamped,
                    output ready);
endinterface

// File: hw/rtl/cser_line_unit.sv
// Pipelined clamp of one coordinate with recompute of the other along the line.
`include "assert_macros.svh"

module cser_line_unit #(
    parameter int W = 24
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic signed [W-1:0] in_bt,
    input  logic signed [W-1:0] in_bo,
    input  logic signed [W-1:0] in_vt,
    input  logic signed [W-1:0] in_vo,
    input  logic signed [W:0]   in_dt,
    input  logic signed [W:0]   in_do,
    input  logic                in_flag_p,
    input  logic signed [W-1:0] lo,
    input  logic signed [W-1:0] hi,
    input  logic [cser_pkg::MARGIN_W-1:0] margin,
    output logic                out_valid,
    input  logic                out_ready,
    output logic signed [W-1:0] out_bt,
    output logic signed [W-1:0] out_bo,
    output logic signed [W-1:0] out_vt,
    output logic signed [W-1:0] out_vo,
    output logic signed [W:0]   out_dt,
    output logic signed [W:0]   out_do,
    output logic                out_flag_p,
    output logic                out_flag
);
    import cser_pkg::*;

    localparam int DW = W + 1;
    localparam int MW = W + 1;
    localparam int NW = 2 * MW;
    localparam int QW = W + 1;
    localparam int EW = W + MARGIN_W + 2;
    localparam int CW = 4 * W + 2 * DW + 3;
    localparam int NS = QW + 5;

    // Context word field offsets.
    localparam int O_DO = 3;
    localparam int O_DT = O_DO + DW;
    localparam int O_VO = O_DT + DW;
    localparam int O_VT = O_VO + W;
    localparam int O_BO = O_VT + W;
    localparam int O_BT = O_BO + W;

    localparam logic signed [EW-1:0] C_MAX = EW'((64'sd1 <<< (W - 1)) - 64'sd1);
    localparam logic signed [EW-1:0] C_MIN = -C_MAX - EW'(1);

    function automatic logic signed [W-1:0] sat_f(logic signed [EW-1:0] v);
        logic signed [W-1:0] r;
        if (v > C_MAX)
            r = C_MAX[W-1:0];
        else if (v < C_MIN)
            r = C_MIN[W-1:0];
        else
            r = v[W-1:0];
        return r;
    endfunction

    function automatic logic [MW-1:0] mag_f(logic signed [DW-1:0] v);
        logic [MW-1:0] r;
        r = v[DW-1] ? (~unsigned'(v) + 1'b1) : unsigned'(v);
        return r;
    endfunction

    // Stage valid bits and the ready chain.
    logic [NS-1:0] vld_reg;
    logic [NS:0]   rdy;

    assign rdy[NS] = out_ready;
    for (genvar k = 0; k < NS; k++)
    begin : g_rdy
        assign rdy[k] = !vld_reg[k] || rdy[k+1];
    end
    assign in_ready = rdy[0];

    logic [NS-1:0] vld_in;
    assign vld_in = {vld_reg[NS-2:0], in_valid};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            for (int k = 0; k < NS; k++)
            begin
                if (rdy[k])
                    vld_reg[k] <= vld_in[k];
            end
        end
    end

    // Stage 0: clamp the coordinate into the half-open range.
    logic signed [EW-1:0] hi_m;
    logic signed [W-1:0]  hi_sat;
    logic                 ge0, lt0, flag0, take0;
    logic signed [W-1:0]  vt0;
    logic [CW-1:0]        ctx0;

    always_comb
    begin
        hi_m   = EW'(hi) - EW'(signed'({1'b0, margin}));
        hi_sat = sat_f(hi_m);
        ge0    = in_vt >= hi;
        lt0    = in_vt < lo;
        vt0    = ge0 ? hi_sat : (lt0 ? lo : in_vt);
        flag0  = ge0 || lt0;
        take0  = flag0 && (in_dt != '0);
        ctx0   = {in_bt, in_bo, vt0, in_vo, in_dt, in_do, in_flag_p, flag0, take0};
    end

    logic [CW-1:0] ctx_reg [NS];
    logic [CW-1:0] ctx_fin;

    // Stage 1: magnitudes and result sign.
    logic [MW-1:0]       a_reg, b_reg, ud1_reg;
    logic                neg1_reg;
    logic signed [DW-1:0] diff1;
    logic signed [DW-1:0] do1, dt1;

    always_comb
    begin
        diff1 = DW'(signed'(ctx_reg[0][O_VT +: W])) - DW'(signed'(ctx_reg[0][O_BT +: W]));
        do1   = signed'(ctx_reg[0][O_DO +: DW]);
        dt1   = signed'(ctx_reg[0][O_DT +: DW]);
    end

    // Stage 2: product of magnitudes.
    logic [NW-1:0] num2_reg;
    logic [MW-1:0] ud2_reg;
    logic          neg2_reg;

    always_ff @(posedge clk)
    begin
        if (rdy[1])
        begin
            a_reg    <= mag_f(do1);
            b_reg    <= mag_f(diff1);
            ud1_reg  <= mag_f(dt1);
            neg1_reg <= do1[DW-1] ^ diff1[DW-1] ^ dt1[DW-1];
        end
        if (rdy[2])
        begin
            num2_reg <= NW'(a_reg) * NW'(b_reg);
            ud2_reg  <= ud1_reg;
            neg2_reg <= neg1_reg;
        end
    end

    // Divider stages: one quotient bit per stage, overflow caught up front.
    logic [NW-1:0] dv_r_reg   [QW+1];
    logic [QW-1:0] dv_q_reg   [QW+1];
    logic          dv_ovf_reg [QW+1];
    logic [MW-1:0] dv_ud_reg  [QW+1];
    logic          dv_neg_reg [QW+1];
    logic [NW-1:0] dv_r_next  [QW+1];
    logic [QW-1:0] dv_q_next  [QW+1];

    always_comb
    begin
        dv_r_next[0] = num2_reg;
        dv_q_next[0] = '0;
        for (int j = 1; j <= QW; j++)
        begin
            dv_r_next[j] = dv_r_reg[j-1];
            dv_q_next[j] = dv_q_reg[j-1];
            if (dv_r_reg[j-1] >= (NW'(dv_ud_reg[j-1]) << (QW - j)))
            begin
                dv_r_next[j] = dv_r_reg[j-1] - (NW'(dv_ud_reg[j-1]) << (QW - j));
                dv_q_next[j][QW-j] = 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy[3])
        begin
            dv_r_reg[0]   <= dv_r_next[0];
            dv_q_reg[0]   <= dv_q_next[0];
            dv_ovf_reg[0] <= num2_reg >= (NW'(ud2_reg) << QW);
            dv_ud_reg[0]  <= ud2_reg;
            dv_neg_reg[0] <= neg2_reg;
        end
        for (int j = 1; j <= QW; j++)
        begin
            if (rdy[3+j])
            begin
                dv_r_reg[j]   <= dv_r_next[j];
                dv_q_reg[j]   <= dv_q_next[j];
                dv_ovf_reg[j] <= dv_ovf_reg[j-1];
                dv_ud_reg[j]  <= dv_ud_reg[j-1];
                dv_neg_reg[j] <= dv_neg_reg[j-1];
            end
        end
    end

    // Final stage: round half away from zero, add to the base, saturate.
    logic                 rnd;
    logic [QW:0]          qf;
    logic signed [EW-1:0] sum;
    logic signed [W-1:0]  vo_fin;
    logic [CW-1:0]        ctx_l;

    always_comb
    begin
        ctx_l = ctx_reg[NS-2];
        rnd   = {dv_r_reg[QW], 1'b0} >= (NW + 1)'(dv_ud_reg[QW]);
        qf    = dv_ovf_reg[QW] ? ((QW + 1)'(1) << QW)
                               : ({1'b0, dv_q_reg[QW]} + (QW + 1)'(rnd));
        sum   = dv_neg_reg[QW] ? (EW'(signed'(ctx_l[O_BO +: W])) - EW'(signed'({1'b0, qf})))
                               : (EW'(signed'(ctx_l[O_BO +: W])) + EW'(signed'({1'b0, qf})));
        vo_fin = ctx_l[0] ? sat_f(sum) : signed'(ctx_l[O_VO +: W]);
        ctx_fin = ctx_l;
        ctx_fin[O_VO +: W] = vo_fin;
    end

    // Context words travel alongside the arithmetic.
    always_ff @(posedge clk)
    begin
        if (rdy[0])
            ctx_reg[0] <= ctx0;
        for (int k = 1; k < NS - 1; k++)
        begin
            if (rdy[k])
                ctx_reg[k] <= ctx_reg[k-1];
        end
        if (rdy[NS-1])
            ctx_reg[NS-1] <= ctx_fin;
    end

    assign out_valid  = vld_reg[NS-1];
    assign out_bt     = signed'(ctx_reg[NS-1][O_BT +: W]);
    assign out_bo     = signed'(ctx_reg[NS-1][O_BO +: W]);
    assign out_vt     = signed'(ctx_reg[NS-1][O_VT +: W]);
    assign out_vo     = signed'(ctx_reg[NS-1][O_VO +: W]);
    assign out_dt     = signed'(ctx_reg[NS-1][O_DT +: DW]);
    assign out_do     = signed'(ctx_reg[NS-1][O_DO +: DW]);
    assign out_flag_p = ctx_reg[NS-1][2];
    assign out_flag   = ctx_reg[NS-1][1];

    // A stalled result stays put until taken.
    `CSER_ASSERT_NXT(a_hold, clk, rst_n, vld_reg[NS-1] && !out_ready, vld_reg[NS-1] && $stable(ctx_reg[NS-1]))
    // Backpressure at the input only when every stage is full and the output is blocked.
    `CSER_ASSERT_IMP(a_full, clk, rst_n, !in_ready, vld_reg[NS-1] && !out_ready)
    // A finished division without overflow leaves a remainder below the divisor.
    `CSER_ASSERT_IMP(a_rem, clk, rst_n, vld_reg[QW+3] && ctx_reg[QW+3][0] && !dv_ovf_reg[QW], dv_r_reg[QW] < NW'(dv_ud_reg[QW]))

endmodule

// File: hw/rtl/clip_segment_end_to_rect_core.sv
// Top level of the segment end clipper: configuration registers and two clamp units.
//
//  Channel    Role    Carries
//  segment    sink    inside_x, inside_y, outside_x, outside_y
//  result     source  clipped_x, clipped_y, x_was_clamped, y_was_clamped
//  cfg_*      write   clip_left, clip_top, clip_right, clip_bottom, edge_margin
//
// One word is accepted per cycle unless a stall at the result has filled every stage.
// Each clamp unit spends one stage per quotient bit in its restoring divider.
// Reset clears all valid bits and loads the configuration defaults.
// A stall at the result propagates back only through full stages, so bubbles are
// squeezed out and no word is lost or repeated.
module clip_segment_end_to_rect_core #(
    parameter int COORD_WIDTH   = 24,
    parameter int FRACTION_BITS = 8
) (
    input  logic clk,
    input  logic rst_n,
    input  logic cfg_we,
    input  logic [cser_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [(COORD_WIDTH > 16 ? COORD_WIDTH : 16)-1:0] cfg_data,
    cser_in_if.sink    segment,
    cser_out_if.source result
);
    import cser_pkg::*;

    localparam int W = COORD_WIDTH;
    localparam logic signed [W-1:0] C_MAX = W'((64'sd1 <<< (W - 1)) - 64'sd1);
    localparam logic [MARGIN_W-1:0] MARGIN_RST =
        MARGIN_W'(((5 << FRACTION_BITS) + 50) / 100);

    logic signed [W-1:0]   left_reg, top_reg, right_reg, bottom_reg;
    logic [MARGIN_W-1:0]   margin_reg;

    // Configuration writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            left_reg   <= '0;
            top_reg    <= '0;
            right_reg  <= C_MAX;
            bottom_reg <= C_MAX;
            margin_reg <= MARGIN_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_LEFT:   left_reg   <= signed'(cfg_data[W-1:0]);
                CFG_TOP:    top_reg    <= signed'(cfg_data[W-1:0]);
                CFG_RIGHT:  right_reg  <= signed'(cfg_data[W-1:0]);
                CFG_BOTTOM: bottom_reg <= signed'(cfg_data[W-1:0]);
                CFG_MARGIN: margin_reg <= cfg_data[MARGIN_W-1:0];
                default:    ;
            endcase
        end
    end

    // Segment deltas between the two input points.
    logic signed [W:0] dx, dy;
    assign dx = (W + 1)'(segment.outside_x) - (W + 1)'(segment.inside_x);
    assign dy = (W + 1)'(segment.outside_y) - (W + 1)'(segment.inside_y);

    logic                u1_valid, u1_ready, u1_flag_p, u1_flag;
    logic signed [W-1:0] u1_bt, u1_bo, u1_vt, u1_vo;
    logic signed [W:0]   u1_dt, u1_do;
    logic signed [W-1:0] u2_bt, u2_bo;
    logic signed [W:0]   u2_dt, u2_do;

    // X clamp, Y recomputed along the line.
    cser_line_unit #(.W(W)) u_x (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (segment.valid),
        .in_ready  (segment.ready),
        .in_bt     (segment.inside_x),
        .in_bo     (segment.inside_y),
        .in_vt     (segment.outside_x),
        .in_vo     (segment.outside_y),
        .in_dt     (dx),
        .in_do     (dy),
        .in_flag_p (1'b0),
        .lo        (left_reg),
        .hi        (right_reg),
        .margin    (margin_reg),
        .out_valid (u1_valid),
        .out_ready (u1_ready),
        .out_bt    (u1_bt),
        .out_bo    (u1_bo),
        .out_vt    (u1_vt),
        .out_vo    (u1_vo),
        .out_dt    (u1_dt),
        .out_do    (u1_do),
        .out_flag_p(u1_flag_p),
        .out_flag  (u1_flag)
    );

    // Y clamp, X recomputed; roles of the axes are swapped.
    cser_line_unit #(.W(W)) u_y (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (u1_valid),
        .in_ready  (u1_ready),
        .in_bt     (u1_bo),
        .in_bo     (u1_bt),
        .in_vt     (u1_vo),
        .in_vo     (u1_vt),
        .in_dt     (u1_do),
        .in_do     (u1_dt),
        .in_flag_p (u1_flag),
        .lo        (top_reg),
        .hi        (bottom_reg),
        .margin    (margin_reg),
        .out_valid (result.valid),
        .out_ready (result.ready),
        .out_bt    (u2_bt),
        .out_bo    (u2_bo),
        .out_vt    (result.clipped_y),
        .out_vo    (result.clipped_x),
        .out_dt    (u2_dt),
        .out_do    (u2_do),
        .out_flag_p(result.x_was_clamped),
        .out_flag  (result.y_was_clamped)
    );

    // The first unit never sets the passed-through flag; only its own flag matters.
    logic unused_bits;
    assign unused_bits = ^{u1_flag_p, u2_bt, u2_bo, u2_dt, u2_do};

endmodule

// File: bench/clip_segment_end_to_rect_core_test.sv
// Testbench for the segment end clipper: random and directed segments checked against a predictor.
module clip_segment_end_to_rect_core_test;
    timeunit 1ns;
    timeprecision 1ps;
    import cser_pkg::*;

    localparam int W = 24;
    localparam longint CMAX = (64'sd1 <<< (W - 1)) - 1;
    localparam longint CMIN = -(64'sd1 <<< (W - 1));
    localparam int LATENCY = 2 * (W + 6);
    localparam int WATCHDOG_LIMIT = 20000;

    typedef struct packed {
        logic signed [W-1:0] ix;
        logic signed [W-1:0] iy;
        logic signed [W-1:0] ox;
        logic signed [W-1:0] oy;
    } segment_t;

    typedef struct packed {
        logic signed [W-1:0] px;
        logic signed [W-1:0] py;
        logic                fx;
        logic                fy;
    } point_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [W-1:0] cfg_data = '0;

    cser_in_if  #(.W(W)) seg_bus ();
    cser_out_if #(.W(W)) res_bus ();

    clip_segment_end_to_rect_core #(.COORD_WIDTH(W), .FRACTION_BITS(8)) DUT (
        .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
        .cfg_data(cfg_data), .segment(seg_bus.sink), .result(res_bus.source)
    );

    always #5 clk = ~clk;

    // Predictor copy of the rectangle registers.
    longint rect_left, rect_top, rect_right, rect_bottom, rect_margin;

    segment_t pending_segments[$];
    point_t   expected_points[$];
    int       error_count = 0;
    int       idle_cycles = 0;

    function automatic longint saturate(longint v);
        if (v > CMAX) return CMAX;
        if (v < CMIN) return CMIN;
        return v;
    endfunction

    // base + round_half_away(a * b / d), saturated; products fit in 128 bits.
    function automatic longint walk_line(longint base, longint a, longint b, longint d);
        logic signed [127:0] num, q, r, ad;
        num = 128'(a) * 128'(b);
        ad = (d < 0) ? -128'(d) : 128'(d);
        if (num < 0) num = -num;
        q = num / ad;
        r = num % ad;
        if (2 * r >= ad) q = q + 1;
        if (((a < 0) != (b < 0)) != (d < 0)) q = -q;
        q = q + 128'(base);
        if (q > 128'(CMAX)) return CMAX;
        if (q < 128'(CMIN)) return CMIN;
        return longint'(q);
    endfunction

    function automatic bit clamp_edge(ref longint v, input longint lo, input longint hi);
        if (v >= hi) begin
            v = saturate(hi - rect_margin);
            return 1'b1;
        end
        if (v < lo) begin
            v = lo;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic point_t clip_point(segment_t s);
        longint ix, iy, x, y, dx, dy;
        point_t p;
        ix = s.ix; iy = s.iy; x = s.ox; y = s.oy;
        dx = x - ix; dy = y - iy;
        p.fx = clamp_edge(x, rect_left, rect_right);
        if (p.fx && dx != 0) y = walk_line(iy, dy, x - ix, dx);
        p.fy = clamp_edge(y, rect_top, rect_bottom);
        if (p.fy && dy != 0) x = walk_line(ix, dx, y - iy, dy);
        p.px = x[W-1:0];
        p.py = y[W-1:0];
        return p;
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        $display("mismatch %s: got %0d expected %0d", what, got, want);
        error_count++;
    endtask

    // Driver: presents queued segments at the falling edge with random gaps.
    int send_gap = 0;
    bit hold_off = 1'b0;
    bit seg_taken = 1'b0;
    initial
    begin
        seg_bus.valid = 1'b0;
        {seg_bus.inside_x, seg_bus.inside_y, seg_bus.outside_x, seg_bus.outside_y} = '0;
    end

    // Input acceptance is seen at the rising edge, where the point is predicted.
    always @(posedge clk)
    begin
        if (rst_n && seg_bus.valid && seg_bus.ready)
        begin
            expected_points.push_back(clip_point(pending_segments.pop_front()));
            seg_taken <= 1'b1;
        end
        else
            seg_taken <= 1'b0;
    end

    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (seg_taken)
                send_gap = $urandom_range(0, 3);
            // A word on offer stays unchanged until it is taken.
            if (!seg_bus.valid || seg_taken)
            begin
                if (send_gap > 0)
                begin
                    send_gap--;
                    seg_bus.valid <= 1'b0;
                end
                else if (pending_segments.size() > 0 && !hold_off)
                begin
                    seg_bus.valid <= 1'b1;
                    {seg_bus.inside_x, seg_bus.inside_y, seg_bus.outside_x,
                     seg_bus.outside_y} <= pending_segments[0];
                end
                else
                    seg_bus.valid <= 1'b0;
            end
        end
    end

    // Monitor: ready with random stalls, checks each word at the rising edge.
    int recv_gap = 0;
    initial res_bus.ready = 1'b0;
    always @(negedge clk)
    begin
        if (recv_gap > 0)
        begin
            recv_gap--;
            res_bus.ready <= 1'b0;
        end
        else
        begin
            res_bus.ready <= 1'b1;
            if (res_bus.ready && $urandom_range(0, 1)) recv_gap = $urandom_range(0, 3);
        end
    end

    always @(posedge clk)
    begin
        point_t want;
        if (rst_n && res_bus.valid && res_bus.ready)
        begin
            if (expected_points.size() == 0)
                report_mismatch("unexpected word", 0, 0);
            else
            begin
                want = expected_points.pop_front();
                if (res_bus.clipped_x !== want.px)
                    report_mismatch("clipped_x", res_bus.clipped_x, want.px);
                if (res_bus.clipped_y !== want.py)
                    report_mismatch("clipped_y", res_bus.clipped_y, want.py);
                if (res_bus.x_was_clamped !== want.fx)
                    report_mismatch("x_was_clamped", res_bus.x_was_clamped, want.fx);
                if (res_bus.y_was_clamped !== want.fy)
                    report_mismatch("y_was_clamped", res_bus.y_was_clamped, want.fy);
            end
        end
    end

    // Watchdog over cycles in which no word moves on either side.
    always @(posedge clk)
    begin
        if ((seg_bus.valid && seg_bus.ready) || (res_bus.valid && res_bus.ready)
            || (pending_segments.size() == 0 && expected_points.size() == 0))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("== FAIL ==");
            $finish;
        end
    end

    function automatic logic [W-1:0] random_coord();
        case ($urandom_range(0, 5))
            0: return W'(CMAX);
            1: return W'(CMIN);
            2: return W'($urandom_range(0, 2000)) - W'(1000);
            default: return W'($urandom);
        endcase
    endfunction

    task automatic wait_drained();
        while (pending_segments.size() > 0 || expected_points.size() > 0 || seg_bus.valid)
            @(posedge clk);
        repeat (LATENCY + 4) @(posedge clk);
    endtask

    task automatic write_reg(cser_cfg_idx_t idx, longint value);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= W'(value);
        @(negedge clk);
        cfg_we <= 1'b0;
        case (idx)
            CFG_LEFT:   rect_left = value;
            CFG_TOP:    rect_top = value;
            CFG_RIGHT:  rect_right = value;
            CFG_BOTTOM: rect_bottom = value;
            default:    rect_margin = value & 16'hFFFF;
        endcase
    endtask

    task automatic set_rect(longint l, longint t, longint r, longint b, longint m);
        write_reg(CFG_LEFT, l);
        write_reg(CFG_TOP, t);
        write_reg(CFG_RIGHT, r);
        write_reg(CFG_BOTTOM, b);
        write_reg(CFG_MARGIN, m);
    endtask

    function automatic segment_t make_seg(longint a, longint b, longint c, longint d);
        segment_t s;
        s.ix = W'(a); s.iy = W'(b); s.ox = W'(c); s.oy = W'(d);
        return s;
    endfunction

    // Random segments: mostly an inside point in the rectangle, plus noise.
    task automatic queue_random(int count, longint l, longint t, longint r, longint b);
        segment_t s;
        repeat (count)
        begin
            if ($urandom_range(0, 3) != 0 && r > l + 1 && b > t + 1)
            begin
                s.ix = W'(l + longint'($urandom) % (r - l));
                s.iy = W'(t + longint'($urandom) % (b - t));
            end
            else
            begin
                s.ix = random_coord();
                s.iy = random_coord();
            end
            s.ox = random_coord();
            s.oy = random_coord();
            pending_segments.push_back(s);
        end
    endtask

    initial
    begin
        rect_left = 0; rect_top = 0; rect_right = CMAX; rect_bottom = CMAX; rect_margin = 13;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed segments at reset settings: in range, both edges, zero deltas.
        pending_segments.push_back(make_seg(100, 100, 200, 300));
        pending_segments.push_back(make_seg(100, 100, CMAX, CMAX));
        pending_segments.push_back(make_seg(100, 100, CMIN, CMIN));
        pending_segments.push_back(make_seg(100, 100, 100, CMIN));
        pending_segments.push_back(make_seg(100, 100, CMIN, 100));
        pending_segments.push_back(make_seg(CMAX, CMIN, CMIN, CMAX));
        pending_segments.push_back(make_seg(0, 0, 0, 0));
        pending_segments.push_back(make_seg(-1, -1, -1, -1));
        wait_drained();

        // Small box with no margin and half-way rounding, then inverted edges with a wide margin.
        set_rect(-1000, -500, 1000, 500, 0);
        pending_segments.push_back(make_seg(0, 0, 2000, 1001));
        pending_segments.push_back(make_seg(0, 0, 3000, -1));
        pending_segments.push_back(make_seg(1, 1, -3000, 2));
        pending_segments.push_back(make_seg(0, 0, 1000, 500));
        pending_segments.push_back(make_seg(0, 0, -1000, -500));
        pending_segments.push_back(make_seg(5000, 5000, 6000, 7000));
        wait_drained();
        set_rect(100, 100, 50, 50, 65535);
        pending_segments.push_back(make_seg(0, 0, 10, 20));
        pending_segments.push_back(make_seg(70, 70, 80, 90));
        pending_segments.push_back(make_seg(CMIN, CMAX, CMAX, CMIN));
        wait_drained();
        set_rect(CMIN, CMIN, CMIN, CMIN, 65535);
        pending_segments.push_back(make_seg(0, 0, 5, 7));
        pending_segments.push_back(make_seg(CMAX, CMAX, CMIN, CMIN));
        wait_drained();

        // Random phases under several rectangles.
        set_rect(0, 0, CMAX, CMAX, 13);
        queue_random(150, 0, 0, CMAX, CMAX);
        wait_drained();
        set_rect(-2000, -1500, 2500, 1800, 7);
        queue_random(150, -2000, -1500, 2500, 1800);
        // Part way through, the sender holds off until every result so far has come.
        repeat (60) @(posedge clk);
        hold_off = 1'b1;
        while (expected_points.size() > 0 || seg_bus.valid) @(posedge clk);
        hold_off = 1'b0;
        wait_drained();
        set_rect(CMIN, CMIN, CMAX, CMAX, 40000);
        queue_random(150, CMIN, CMIN, CMAX, CMAX);
        wait_drained();
        set_rect(-300000, 200000, 900000, 210000, $urandom_range(0, 65535));
        queue_random(150, -300000, 200000, 900000, 210000);
        wait_drained();

        if (error_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end
endmodule
